// ----- hdl/acu_pkg.sv -----
// Shared types and constants for the alarm counter unit.
// Holds field widths, operation and status codes, controller states and the
// command and status structs. No dependencies.
package acu_pkg;

    localparam int OP_W        = 3;
    localparam int AID_W       = 4;
    localparam int CID_W       = 2;
    localparam int VAL_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int MAP_W       = 8;
    localparam int MAP_IDX_W   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_SET_REL = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_ABS = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ACTIVE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COUNTER0_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER1_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MAP    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REL_WAIT,
        S_SCAN,
        S_SCAN_WAIT,
        S_FINISH
    } acu_state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic rel_commit;
        logic scan;
        logic scan_commit;
        logic load_out;
    } acu_cmd_t;

    typedef struct packed {
        logic exec_rel_mod;
        logic exec_tick;
        logic scan_mod;
        logic scan_last;
        logic mod_done;
    } acu_sts_t;

endpackage

// ----- hdl/acu_stream_if.sv -----
// Request and response channel interfaces of the alarm counter unit.
// Depends on acu_pkg for the field widths.
interface acu_req_if;
    logic                          valid;
    logic                          ready;
    logic [acu_pkg::OP_W-1:0]      operation;
    logic [acu_pkg::AID_W-1:0]     alarm_id;
    logic [acu_pkg::CID_W-1:0]     counter_id;
    logic [acu_pkg::VAL_W-1:0]     tick_value;
    logic [acu_pkg::VAL_W-1:0]     cycle_value;

    modport source (output valid, operation, alarm_id, counter_id, tick_value, cycle_value,
                    input ready);
    modport sink (input valid, operation, alarm_id, counter_id, tick_value, cycle_value,
                  output ready);
endinterface

interface acu_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [acu_pkg::STATUS_W-1:0]  status;
    logic [acu_pkg::VAL_W-1:0]     counter_value;
    logic [acu_pkg::VAL_W-1:0]     counter_max;
    logic [acu_pkg::MAP_W-1:0]     fired_mask;

    modport source (output valid, status, counter_value, counter_max, fired_mask,
                    input ready);
    modport sink (input valid, status, counter_value, counter_max, fired_mask,
                  output ready);
endinterface

// ----- hdl/acu_mod.sv -----
// Iterative remainder unit: one restoring step per cycle, W steps per operation.
// Used by the datapath to reduce expiry times modulo a counter's maximum plus one.
module acu_mod #(
    parameter int W = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     div_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic [W-1:0]     rem_step;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign rem_step = (trial >= {1'b0, div_reg}) ? diff[W-1:0] : trial[W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/acu_ctrl.sv -----
// Controller of the alarm counter unit: sequences decode, the alarm scan of a
// tick, remainder waits and the output register. Depends on acu_pkg.
module acu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  acu_pkg::acu_sts_t sts,
    output acu_pkg::acu_cmd_t cmd
);

    acu_pkg::acu_state_t state_reg;
    acu_pkg::acu_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acu_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = acu_pkg::S_EXEC;
            end
            acu_pkg::S_EXEC:
            begin
                if (sts.exec_rel_mod)
                    state_next = acu_pkg::S_REL_WAIT;
                else if (sts.exec_tick)
                    state_next = acu_pkg::S_SCAN;
                else
                    state_next = acu_pkg::S_FINISH;
            end
            acu_pkg::S_REL_WAIT:
            begin
                if (sts.mod_done)
                    state_next = acu_pkg::S_FINISH;
            end
            acu_pkg::S_SCAN:
            begin
                if (sts.scan_mod)
                    state_next = acu_pkg::S_SCAN_WAIT;
                else if (sts.scan_last)
                    state_next = acu_pkg::S_FINISH;
            end
            acu_pkg::S_SCAN_WAIT:
            begin
                if (sts.mod_done)
                    state_next = sts.scan_last ? acu_pkg::S_FINISH : acu_pkg::S_SCAN;
            end
            acu_pkg::S_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                    state_next = acu_pkg::S_IDLE;
            end
            default:
                state_next = acu_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            acu_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            acu_pkg::S_EXEC:      cmd.exec        = 1'b1;
            acu_pkg::S_REL_WAIT:  cmd.rel_commit  = sts.mod_done;
            acu_pkg::S_SCAN:      cmd.scan        = 1'b1;
            acu_pkg::S_SCAN_WAIT: cmd.scan_commit = sts.mod_done;
            acu_pkg::S_FINISH:    cmd.load_out    = !out_valid_reg || rsp_ready;
            default:              cmd             = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acu_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

// ----- hdl/acu_dp.sv -----
// Datapath of the alarm counter unit: configuration, counters, alarm table,
// result register and the remainder unit. Depends on acu_pkg and acu_mod.
module acu_dp #(
    parameter int NUM_ALARMS   = 8,
    parameter int NUM_COUNTERS = 2,
    parameter int TW           = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [acu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [acu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [acu_pkg::OP_W-1:0]         operation,
    input  logic [acu_pkg::AID_W-1:0]        alarm_id,
    input  logic [acu_pkg::CID_W-1:0]        counter_id,
    input  logic [acu_pkg::VAL_W-1:0]        tick_value,
    input  logic [acu_pkg::VAL_W-1:0]        cycle_value,
    input  acu_pkg::acu_cmd_t                cmd,
    output acu_pkg::acu_sts_t                sts,
    output logic [acu_pkg::STATUS_W-1:0]     status,
    output logic [acu_pkg::VAL_W-1:0]        counter_value,
    output logic [acu_pkg::VAL_W-1:0]        counter_max,
    output logic [acu_pkg::MAP_W-1:0]        fired_mask
);

    localparam int AW        = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int CW        = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int AID_W     = acu_pkg::AID_W;
    localparam int CID_W     = acu_pkg::CID_W;
    localparam int VAL_W     = acu_pkg::VAL_W;
    localparam int MAP_IDX_W = acu_pkg::MAP_IDX_W;
    localparam int CFG_IDX_W = acu_pkg::CFG_IDX_W;

    logic [TW-1:0]                   max_reg [NUM_COUNTERS];
    logic [acu_pkg::MAP_W-1:0]       map_reg;
    logic [TW-1:0]                   tick_count_reg [NUM_COUNTERS];
    logic [TW-1:0]                   expiry_reg [NUM_ALARMS];
    logic [TW-1:0]                   reload_reg [NUM_ALARMS];
    logic [NUM_ALARMS-1:0]           armed_reg;
    logic [acu_pkg::MAP_W-1:0]       fired_reg;
    logic [AW-1:0]                   scan_idx_reg;

    logic [acu_pkg::OP_W-1:0]        op_reg;
    logic [AID_W-1:0]                aid_reg;
    logic [CID_W-1:0]                cid_reg;
    logic [TW-1:0]                   tval_reg;
    logic [TW-1:0]                   cval_reg;

    logic [acu_pkg::STATUS_W-1:0]    status_reg;
    logic                            report_reg;
    logic [CW-1:0]                   sel_reg;

    logic [acu_pkg::STATUS_W-1:0]    out_status_reg;
    logic [VAL_W-1:0]                out_value_reg;
    logic [VAL_W-1:0]                out_max_reg;
    logic [acu_pkg::MAP_W-1:0]       out_fired_reg;

    logic                            aid_ok;
    logic                            cid_ok;
    logic [AW-1:0]                   aidx;
    logic [CW-1:0]                   cidx;
    logic                            bound;
    logic                            bound_ok;
    logic                            is_alarm_op;
    logic [CW-1:0]                   ctr_sel;
    logic [TW-1:0]                   cur_tick;
    logic [TW-1:0]                   cur_max;
    logic [TW:0]                     rel_sum;
    logic                            rel_over;
    logic [TW:0]                     tick_inc;
    logic [TW-1:0]                   tick_next;
    logic [TW-1:0]                   arm_expiry;
    logic [acu_pkg::STATUS_W-1:0]    status_c;
    logic                            report_c;
    logic                            do_arm;
    logic                            do_disarm;
    logic                            do_tick;
    logic                            exec_rel_mod;

    logic [MAP_IDX_W-1:0]            scan_map_idx;
    logic [TW-1:0]                   sc_tick;
    logic [TW-1:0]                   sc_max;
    logic                            hit;
    logic                            cyclic;
    logic [TW:0]                     e_sum;
    logic                            e_over;
    logic                            scan_mod;

    logic                            mod_start;
    logic [TW:0]                     mod_dividend;
    logic [TW:0]                     mod_divisor;
    logic                            mod_done;
    logic [TW:0]                     mod_rem;

    // Decode of the latched request.
    assign aid_ok      = aid_reg < AID_W'(NUM_ALARMS);
    assign cid_ok      = cid_reg < CID_W'(NUM_COUNTERS);
    assign aidx        = aid_reg[AW-1:0];
    assign cidx        = cid_reg[CW-1:0];
    assign bound       = map_reg[aid_reg[MAP_IDX_W-1:0]];
    assign bound_ok    = {{(CID_W-1){1'b0}}, bound} < CID_W'(NUM_COUNTERS);
    assign is_alarm_op = (op_reg == acu_pkg::OP_SET_REL) || (op_reg == acu_pkg::OP_SET_ABS)
                         || (op_reg == acu_pkg::OP_CANCEL);

    always_comb
    begin
        if (is_alarm_op)
            ctr_sel = bound_ok ? CW'(bound) : '0;
        else
            ctr_sel = cid_ok ? cidx : '0;
    end

    assign cur_tick   = tick_count_reg[ctr_sel];
    assign cur_max    = max_reg[ctr_sel];
    assign rel_sum    = {1'b0, cur_tick} + {1'b0, tval_reg};
    assign rel_over   = rel_sum > {1'b0, cur_max};
    assign tick_inc   = {1'b0, cur_tick} + (TW+1)'(1);
    assign tick_next  = (tick_inc > {1'b0, cur_max}) ? '0 : tick_inc[TW-1:0];
    assign arm_expiry = (op_reg == acu_pkg::OP_SET_REL) ? rel_sum[TW-1:0] : tval_reg;

    always_comb
    begin
        status_c  = acu_pkg::ST_OK;
        report_c  = 1'b0;
        do_arm    = 1'b0;
        do_disarm = 1'b0;
        do_tick   = 1'b0;
        case (op_reg)
            acu_pkg::OP_SET_REL, acu_pkg::OP_SET_ABS, acu_pkg::OP_CANCEL:
            begin
                if (!aid_ok)
                    status_c = acu_pkg::ST_BAD_ID;
                else if (op_reg == acu_pkg::OP_CANCEL)
                begin
                    if (!armed_reg[aidx])
                        status_c = acu_pkg::ST_NOT_ACTIVE;
                    else
                        do_disarm = 1'b1;
                end
                else if (armed_reg[aidx])
                    status_c = acu_pkg::ST_ACTIVE;
                else if ((op_reg == acu_pkg::OP_SET_REL) && !bound_ok)
                    status_c = acu_pkg::ST_BAD_ID;
                else
                    do_arm = 1'b1;
                report_c = (status_c != acu_pkg::ST_BAD_ID) && bound_ok;
            end
            acu_pkg::OP_TICK, acu_pkg::OP_READ:
            begin
                if (!cid_ok)
                    status_c = acu_pkg::ST_BAD_ID;
                else
                begin
                    report_c = 1'b1;
                    do_tick  = (op_reg == acu_pkg::OP_TICK);
                end
            end
            default:
                status_c = acu_pkg::ST_BAD_ID;
        endcase
    end

    assign exec_rel_mod = do_arm && (op_reg == acu_pkg::OP_SET_REL) && rel_over;

    // One alarm is examined per scan step; it hits only if bound to the tick's counter.
    assign scan_map_idx = MAP_IDX_W'(scan_idx_reg);
    assign sc_tick      = tick_count_reg[sel_reg];
    assign sc_max       = max_reg[sel_reg];
    assign hit          = armed_reg[scan_idx_reg]
                          && (cid_reg == {{(CID_W-1){1'b0}}, map_reg[scan_map_idx]})
                          && (expiry_reg[scan_idx_reg] == sc_tick);
    assign cyclic       = reload_reg[scan_idx_reg] != '0;
    assign e_sum        = {1'b0, expiry_reg[scan_idx_reg]} + {1'b0, reload_reg[scan_idx_reg]};
    assign e_over       = e_sum > {1'b0, sc_max};
    assign scan_mod     = hit && cyclic && e_over;

    assign mod_start    = (cmd.exec && exec_rel_mod) || (cmd.scan && scan_mod);
    assign mod_dividend = cmd.exec ? rel_sum : e_sum;
    assign mod_divisor  = cmd.exec ? ({1'b0, cur_max} + (TW+1)'(1))
                                   : ({1'b0, sc_max} + (TW+1)'(1));

    acu_mod #(
        .W (TW + 1)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COUNTERS; c++)
            begin
                max_reg[c]        <= '1;
                tick_count_reg[c] <= '0;
            end
            for (int a = 0; a < NUM_ALARMS; a++)
            begin
                expiry_reg[a] <= '0;
                reload_reg[a] <= '0;
            end
            map_reg      <= '0;
            armed_reg    <= '0;
            fired_reg    <= '0;
            scan_idx_reg <= '0;
            status_reg   <= acu_pkg::ST_OK;
            report_reg   <= 1'b0;
            sel_reg      <= '0;
        end
        else
        begin
            for (int c = 0; c < NUM_COUNTERS; c++)
            begin
                if (cfg_we && (cfg_index == CFG_IDX_W'(c)))
                    max_reg[c] <= cfg_wdata[TW-1:0];
            end
            if (cfg_we && (cfg_index == acu_pkg::REG_ALARM_MAP))
                map_reg <= cfg_wdata[acu_pkg::MAP_W-1:0];

            if (cmd.exec)
            begin
                status_reg   <= status_c;
                report_reg   <= report_c;
                sel_reg      <= ctr_sel;
                fired_reg    <= '0;
                scan_idx_reg <= '0;
                if (do_arm)
                begin
                    armed_reg[aidx]  <= 1'b1;
                    reload_reg[aidx] <= cval_reg;
                    if (!exec_rel_mod)
                        expiry_reg[aidx] <= arm_expiry;
                end
                if (do_disarm)
                begin
                    armed_reg[aidx]  <= 1'b0;
                    reload_reg[aidx] <= '0;
                end
                if (do_tick)
                    tick_count_reg[cidx] <= tick_next;
            end

            if (cmd.rel_commit)
                expiry_reg[aidx] <= mod_rem[TW-1:0];

            if (cmd.scan)
            begin
                if (hit)
                begin
                    fired_reg[scan_map_idx] <= 1'b1;
                    if (!cyclic)
                        armed_reg[scan_idx_reg] <= 1'b0;
                    else if (!e_over)
                        expiry_reg[scan_idx_reg] <= e_sum[TW-1:0];
                end
                if (!scan_mod)
                    scan_idx_reg <= scan_idx_reg + AW'(1);
            end

            if (cmd.scan_commit)
            begin
                expiry_reg[scan_idx_reg] <= mod_rem[TW-1:0];
                scan_idx_reg             <= scan_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= operation;
            aid_reg  <= alarm_id;
            cid_reg  <= counter_id;
            tval_reg <= tick_value[TW-1:0];
            cval_reg <= cycle_value[TW-1:0];
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_value_reg  <= report_reg ? VAL_W'(tick_count_reg[sel_reg]) : '0;
            out_max_reg    <= report_reg ? VAL_W'(max_reg[sel_reg]) : '0;
            out_fired_reg  <= fired_reg;
        end
    end

    assign sts.exec_rel_mod = exec_rel_mod;
    assign sts.exec_tick    = do_tick;
    assign sts.scan_mod     = scan_mod;
    assign sts.scan_last    = scan_idx_reg == AW'(NUM_ALARMS - 1);
    assign sts.mod_done     = mod_done;

    assign status        = out_status_reg;
    assign counter_value = out_value_reg;
    assign counter_max   = out_max_reg;
    assign fired_mask    = out_fired_reg;

endmodule

// ----- hdl/alarm_counter_unit_core.sv -----
// Alarm counter unit top level: one request at a time. A request is latched, executed and
// its result loaded into the output register; a set_rel that wraps also waits for the
// remainder unit, of TW+1 bits, where TW is TICK_WIDTH capped at 16. A tick adds one scan
// step per alarm, plus a remainder wait for each cyclic alarm whose re-arm wraps. The next
// request is accepted once the response is in the output register. Reset clears counters
// and alarms, sets maxima to all ones and the alarm map to zero, immediately.
module alarm_counter_unit_core #(
    parameter int NUM_ALARMS   = 8,
    parameter int NUM_COUNTERS = 2,
    parameter int TICK_WIDTH   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [acu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    acu_req_if.sink                        req,
    acu_rsp_if.source                      rsp
);

    localparam int TW = (TICK_WIDTH < acu_pkg::VAL_W) ? TICK_WIDTH : acu_pkg::VAL_W;

    acu_pkg::acu_cmd_t cmd;
    acu_pkg::acu_sts_t sts;

    acu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    acu_dp #(
        .NUM_ALARMS   (NUM_ALARMS),
        .NUM_COUNTERS (NUM_COUNTERS),
        .TW           (TW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .operation     (req.operation),
        .alarm_id      (req.alarm_id),
        .counter_id    (req.counter_id),
        .tick_value    (req.tick_value),
        .cycle_value   (req.cycle_value),
        .cmd           (cmd),
        .sts           (sts),
        .status        (rsp.status),
        .counter_value (rsp.counter_value),
        .counter_max   (rsp.counter_max),
        .fired_mask    (rsp.fired_mask)
    );

endmodule

// ----- verif/tb_alarm_counter_unit_core.sv -----
`timescale 1ns / 1ps
// Testbench for alarm_counter_unit_core: a directed table, then phases of random requests
// under changing counter maxima and alarm bindings; checks use fixed rows or a predictor.
// Depends on acu_pkg and the acu_req_if and acu_rsp_if interfaces.
module tb_alarm_counter_unit_core;

    localparam int OP_W       = acu_pkg::OP_W;
    localparam int AID_W      = acu_pkg::AID_W;
    localparam int CID_W      = acu_pkg::CID_W;
    localparam int VAL_W      = acu_pkg::VAL_W;
    localparam int STATUS_W   = acu_pkg::STATUS_W;
    localparam int MAP_W      = acu_pkg::MAP_W;
    localparam int CFG_IDX_W  = acu_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = acu_pkg::CFG_DATA_W;

    localparam int NUM_ALARMS      = 8;
    localparam int NUM_COUNTERS    = 2;
    localparam int RAND_PHASES     = 8;
    localparam int BEATS_PER_PHASE = 240;
    localparam int TAIL_CYCLES     = 200;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DIRECTED_ROWS   = 24;

    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [AID_W-1:0] alarm_id;
        logic [CID_W-1:0] counter_id;
        logic [VAL_W-1:0] tick_value;
        logic [VAL_W-1:0] cycle_value;
    } req_fields_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    counter_value;
        logic [VAL_W-1:0]    counter_max;
        logic [MAP_W-1:0]    fired_mask;
    } rsp_fields_t;

    typedef struct packed {
        req_fields_t req;
        logic        typed;
        rsp_fields_t rsp;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    acu_req_if req_ch ();
    acu_rsp_if rsp_ch ();

    alarm_counter_unit_core #(
        .NUM_ALARMS   (NUM_ALARMS),
        .NUM_COUNTERS (NUM_COUNTERS),
        .TICK_WIDTH   (VAL_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Predicted state of the block.
    logic [VAL_W-1:0] ctr_ticks    [NUM_COUNTERS];
    logic [VAL_W-1:0] ctr_limit    [NUM_COUNTERS];
    logic [MAP_W-1:0] alarm_map;
    logic [VAL_W-1:0] alarm_expiry [NUM_ALARMS];
    logic [VAL_W-1:0] alarm_period [NUM_ALARMS];
    logic             alarm_armed  [NUM_ALARMS];

    rsp_fields_t pending_responses [$];
    rsp_fields_t seen_rsp;
    rsp_fields_t oldest_rsp;

    int  mismatches    = 0;
    int  beats_sent    = 0;
    int  ticks_sent    = 0;
    int  alarms_fired  = 0;
    int  stall_left    = 0;
    int  cycle_count   = 0;
    bit  calm_mode     = 1'b0;

    directed_row_t directed_tbl [DIRECTED_ROWS] = '{
        '{'{acu_pkg::OP_READ,    4'd0,  2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_OK,         16'd0, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_READ,    4'd0,  2'd3, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{OP_RSVD5,            4'd0,  2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{OP_RSVD6,            4'd15, 2'd3, 16'hFFFF,  16'hFFFF},  1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{OP_RSVD7,            4'd7,  2'd1, 16'h5A5A,  16'hA5A5},  1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{acu_pkg::OP_SET_ABS, 4'd15, 2'd0, 16'd1,     16'd0},     1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{acu_pkg::OP_CANCEL,  4'd0,  2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_NOT_ACTIVE, 16'd0, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_SET_REL, 4'd0,  2'd0, 16'd2,     16'd0},     1'b1,
          '{acu_pkg::ST_OK,         16'd0, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_SET_REL, 4'd0,  2'd0, 16'd5,     16'd0},     1'b1,
          '{acu_pkg::ST_ACTIVE,     16'd0, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_SET_ABS, 4'd1,  2'd0, 16'd1,     16'd3},     1'b1,
          '{acu_pkg::ST_OK,         16'd0, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_TICK,    4'd0,  2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_OK,         16'd1, 16'hFFFF, 8'h02}},
        '{'{acu_pkg::OP_TICK,    4'd0,  2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_OK,         16'd2, 16'hFFFF, 8'h01}},
        '{'{acu_pkg::OP_TICK,    4'd0,  2'd1, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_OK,         16'd1, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_TICK,    4'd0,  2'd2, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{acu_pkg::OP_SET_ABS, 4'd7,  2'd0, 16'hFFFF,  16'hFFFF},  1'b1,
          '{acu_pkg::ST_OK,         16'd2, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_CANCEL,  4'd1,  2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_OK,         16'd2, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_CANCEL,  4'd1,  2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_NOT_ACTIVE, 16'd2, 16'hFFFF, 8'h00}},
        '{'{acu_pkg::OP_SET_REL, 4'd2,  2'd0, 16'hFFFF,  16'd0},     1'b0, '0},
        '{'{acu_pkg::OP_SET_REL, 4'd3,  2'd0, 16'd0,     16'd1},     1'b0, '0},
        '{'{acu_pkg::OP_SET_ABS, 4'd8,  2'd0, 16'd4,     16'd0},     1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{acu_pkg::OP_CANCEL,  4'd15, 2'd0, 16'd0,     16'd0},     1'b1,
          '{acu_pkg::ST_BAD_ID,     16'd0, 16'd0,    8'h00}},
        '{'{acu_pkg::OP_TICK,    4'd0,  2'd0, 16'd0,     16'd0},     1'b0, '0},
        '{'{acu_pkg::OP_READ,    4'd0,  2'd1, 16'd0,     16'd0},     1'b0, '0},
        '{'{acu_pkg::OP_SET_ABS, 4'd4,  2'd0, 16'd3,     16'd0},     1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int unsigned pick;
        if (calm_mode)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] wrap_tick(input logic [VAL_W-1:0] base,
                                                   input logic [VAL_W-1:0] step,
                                                   input logic [VAL_W-1:0] limit);
        logic [VAL_W:0] sum;
        logic [VAL_W:0] modulus;
        sum     = {1'b0, base} + {1'b0, step};
        modulus = {1'b0, limit} + 1'b1;
        if (sum > {1'b0, limit})
            sum = sum % modulus;
        return sum[VAL_W-1:0];
    endfunction

    function automatic rsp_fields_t compute_response(input req_fields_t b);
        rsp_fields_t r;
        int unsigned aid;
        int unsigned sel;
        r   = '0;
        aid = b.alarm_id;
        if (b.operation == acu_pkg::OP_SET_REL || b.operation == acu_pkg::OP_SET_ABS
            || b.operation == acu_pkg::OP_CANCEL)
        begin
            if (aid >= NUM_ALARMS)
                r.status = acu_pkg::ST_BAD_ID;
            else
            begin
                sel = alarm_map[aid];
                if (b.operation == acu_pkg::OP_CANCEL)
                begin
                    if (!alarm_armed[aid])
                        r.status = acu_pkg::ST_NOT_ACTIVE;
                    else
                    begin
                        alarm_armed[aid]  = 1'b0;
                        alarm_period[aid] = '0;
                    end
                end
                else if (alarm_armed[aid])
                    r.status = acu_pkg::ST_ACTIVE;
                else
                begin
                    if (b.operation == acu_pkg::OP_SET_REL)
                        alarm_expiry[aid] = wrap_tick(ctr_ticks[sel], b.tick_value,
                                                      ctr_limit[sel]);
                    else
                        alarm_expiry[aid] = b.tick_value;
                    alarm_period[aid] = b.cycle_value;
                    alarm_armed[aid]  = 1'b1;
                end
                r.counter_value = ctr_ticks[sel];
                r.counter_max   = ctr_limit[sel];
            end
        end
        else if (b.operation == acu_pkg::OP_TICK || b.operation == acu_pkg::OP_READ)
        begin
            if (b.counter_id >= NUM_COUNTERS)
                r.status = acu_pkg::ST_BAD_ID;
            else
            begin
                sel = b.counter_id;
                if (b.operation == acu_pkg::OP_TICK)
                begin
                    if (ctr_ticks[sel] >= ctr_limit[sel])
                        ctr_ticks[sel] = '0;
                    else
                        ctr_ticks[sel] = ctr_ticks[sel] + 1'b1;
                    for (int i = 0; i < NUM_ALARMS; i++)
                    begin
                        if (alarm_armed[i] && alarm_map[i] == sel[0]
                            && alarm_expiry[i] == ctr_ticks[sel])
                        begin
                            r.fired_mask[i] = 1'b1;
                            if (alarm_period[i] != '0)
                                alarm_expiry[i] = wrap_tick(alarm_expiry[i], alarm_period[i],
                                                            ctr_limit[sel]);
                            else
                                alarm_armed[i] = 1'b0;
                        end
                    end
                end
                r.counter_value = ctr_ticks[sel];
                r.counter_max   = ctr_limit[sel];
            end
        end
        else
            r.status = acu_pkg::ST_BAD_ID;
        return r;
    endfunction

    // Most requests address a real alarm or counter and pick small times or times near the
    // counter's position, so that alarms actually expire; the rest exercise the error paths.
    function automatic req_fields_t random_beat();
        req_fields_t b;
        int unsigned pick;
        int unsigned sel;
        b.alarm_id    = 4'($urandom);
        b.counter_id  = 2'($urandom);
        b.tick_value  = 16'($urandom);
        b.cycle_value = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            b.operation = acu_pkg::OP_TICK;
        else if (pick < 55)
            b.operation = acu_pkg::OP_SET_REL;
        else if (pick < 70)
            b.operation = acu_pkg::OP_SET_ABS;
        else if (pick < 82)
            b.operation = acu_pkg::OP_CANCEL;
        else if (pick < 96)
            b.operation = acu_pkg::OP_READ;
        else
        begin
            case ($urandom_range(0, 2))
                0:       b.operation = OP_RSVD5;
                1:       b.operation = OP_RSVD6;
                default: b.operation = OP_RSVD7;
            endcase
        end
        if ($urandom_range(0, 9) != 0)
        begin
            b.alarm_id   = 4'($urandom_range(0, NUM_ALARMS - 1));
            b.counter_id = 2'($urandom_range(0, NUM_COUNTERS - 1));
        end
        sel  = alarm_map[b.alarm_id[2:0]];
        pick = $urandom_range(0, 99);
        if (pick < 50)
            b.tick_value = 16'($urandom_range(0, 12));
        else if (pick < 75)
            b.tick_value = 16'(ctr_ticks[sel] + $urandom_range(0, 12));
        else if (pick < 90)
            b.tick_value = 16'($urandom_range(0, ctr_limit[sel]));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            b.cycle_value = '0;
        else if (pick < 80)
            b.cycle_value = 16'($urandom_range(1, 8));
        else if (pick < 90)
            b.cycle_value = 16'($urandom_range(0, ctr_limit[sel]));
        return b;
    endfunction

    task automatic send_beat(input req_fields_t beat, input logic typed,
                             input rsp_fields_t fixed);
        rsp_fields_t predicted;
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= beat.operation;
        req_ch.alarm_id    <= beat.alarm_id;
        req_ch.counter_id  <= beat.counter_id;
        req_ch.tick_value  <= beat.tick_value;
        req_ch.cycle_value <= beat.cycle_value;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = compute_response(beat);
        pending_responses.push_back(typed ? fixed : predicted);
        beats_sent++;
        if (beat.operation == acu_pkg::OP_TICK)
            ticks_sent++;
        alarms_fired += $countones(predicted.fired_mask);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            acu_pkg::REG_COUNTER0_MAX: ctr_limit[0] = data;
            acu_pkg::REG_COUNTER1_MAX: ctr_limit[1] = data;
            acu_pkg::REG_ALARM_MAP:    alarm_map = data[MAP_W-1:0];
            default:                   ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            seen_rsp = {rsp_ch.status, rsp_ch.counter_value, rsp_ch.counter_max,
                        rsp_ch.fired_mask};
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                $display("%0t: response beat arrived with nothing outstanding", $time);
            end
            else
            begin
                oldest_rsp = pending_responses.pop_front();
                if (seen_rsp !== oldest_rsp)
                begin
                    mismatches++;
                    $display("%0t: expected status=%0d value=%0d max=%0d fired=%02h,",
                             $time, oldest_rsp.status, oldest_rsp.counter_value,
                             oldest_rsp.counter_max, oldest_rsp.fired_mask,
                             " got status=%0d value=%0d max=%0d fired=%02h",
                             seen_rsp.status, seen_rsp.counter_value,
                             seen_rsp.counter_max, seen_rsp.fired_mask);
                end
            end
        end
    end

    initial
    begin
        do
            @(posedge clk);
        while (cycle_count < CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d responses outstanding.",
                 cycle_count, pending_responses.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [VAL_W-1:0] max0;
        logic [VAL_W-1:0] max1;
        logic [MAP_W-1:0] map_bits;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = '0;
        req_ch.alarm_id    = '0;
        req_ch.counter_id  = '0;
        req_ch.tick_value  = '0;
        req_ch.cycle_value = '0;
        alarm_map          = '0;
        for (int c = 0; c < NUM_COUNTERS; c++)
        begin
            ctr_ticks[c] = '0;
            ctr_limit[c] = '1;
        end
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            alarm_expiry[i] = '0;
            alarm_period[i] = '0;
            alarm_armed[i]  = 1'b0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tbl[k])
            send_beat(directed_tbl[k].req, directed_tbl[k].typed, directed_tbl[k].rsp);
        req_ch.valid <= 1'b0;

        for (int phase = 1; phase <= RAND_PHASES; phase++)
        begin
            while (pending_responses.size() != 0)
                @(posedge clk);
            case (phase)
                1:
                begin
                    max0 = 16'd0;     max1 = 16'hFFFF; map_bits = 8'h00;
                end
                2:
                begin
                    max0 = 16'hFFFF;  max1 = 16'd0;    map_bits = 8'hFF;
                end
                3:
                begin
                    max0 = 16'd5;     max1 = 16'd9;    map_bits = 8'hA5;
                end
                4:
                begin
                    max0 = 16'd1;     max1 = 16'd2;    map_bits = 8'h5A;
                end
                5:
                begin
                    max0     = 16'($urandom_range(0, 20));
                    max1     = 16'($urandom_range(0, 40));
                    map_bits = 8'($urandom);
                end
                6:
                begin
                    max0 = 16'hFFFF;  max1 = 16'hFFFF; map_bits = 8'h0F;
                end
                7:
                begin
                    max0     = 16'($urandom);
                    max1     = 16'($urandom_range(3, 15));
                    map_bits = 8'($urandom);
                end
                default:
                begin
                    max0     = 16'($urandom_range(2, 12));
                    max1     = 16'($urandom_range(2, 12));
                    map_bits = 8'($urandom);
                end
            endcase
            write_reg(acu_pkg::REG_COUNTER0_MAX, max0);
            write_reg(acu_pkg::REG_COUNTER1_MAX, max1);
            write_reg(acu_pkg::REG_ALARM_MAP, {{(CFG_DATA_W - MAP_W){1'b0}}, map_bits});
            calm_mode = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                if (n == BEATS_PER_PHASE / 2)
                    calm_mode = ($urandom_range(0, 3) == 0);
                send_beat(random_beat(), 1'b0, '0);
            end
            req_ch.valid <= 1'b0;
        end

        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected responses never arrived", $time,
                     pending_responses.size());
        end

        $display("Sent %0d requests (%0d ticks) over %0d register settings; %0d alarm expiries.",
                 beats_sent, ticks_sent, RAND_PHASES + 1, alarms_fired);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
